>>> rtl/ssb_pkg.sv
// Shared types, constants and Q16.16 helpers for the selective scan backward block.
// No dependencies; used by the front, queue and back modules and the top level.
package ssb_pkg;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
	localparam int LN2_Q16   = 45426;
	localparam int RECIP_LN2 = 23637;            // floor(2^30 / LN2_Q16)
	localparam int K_OFFSET  = 31;               // negated lowest exponent that is not flushed
	localparam int Z_HI      = 16 * LN2_Q16;     // at or above: exp saturates
	localparam int Z_LO      = -31 * LN2_Q16;    // below: exp flushes to zero
	localparam int Z_BIAS    = K_OFFSET * LN2_Q16;

	typedef struct packed {
		logic signed [31:0] step_size;
		logic signed [31:0] x_in;
		logic signed [31:0] grad_out;
		logic signed [31:0] a_coef;
		logic signed [31:0] b_in;
		logic signed [31:0] c_in;
		logic signed [31:0] h_cur;
		logic signed [31:0] h_prev;
		logic [5:0]         channel;
		logic [3:0]         state_idx;
		logic               first_step;
		logic               last_step;
		logic               out_range;
		logic               row_end;
	} item_t;

	// Saturate a raw 33x33 product after the Q16.16 shift (floor).
	function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
		logic signed [65:0] s;
		s = p >>> 16;
		if (s > 66'sh0_7fffffff) return Q_MAX;
		if (s < -66'sh0_80000000) return Q_MIN;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
		return s[31:0];
	endfunction

	// ceil(2^32 / i) for the Taylor divisors two to six
	function automatic logic [32:0] recip(input logic [2:0] i);
		case (i)
			3'd2:    return 33'd2147483648;
			3'd3:    return 33'd1431655766;
			3'd4:    return 33'd1073741824;
			3'd5:    return 33'd858993460;
			3'd6:    return 33'd715827883;
			default: return 33'd0;
		endcase
	endfunction

endpackage

>>> rtl/ssb_front.sv
// Front end: accepts input beats, flags out-of-range indices and row ends.
// Depends on ssb_pkg.
module ssb_front import ssb_pkg::*; #(
	parameter int CHANNELS   = 64,
	parameter int STATE_SIZE = 16
) (
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] step_size,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] grad_out,
	input  logic signed [31:0] a_coef,
	input  logic signed [31:0] b_in,
	input  logic signed [31:0] c_in,
	input  logic signed [31:0] h_cur,
	input  logic signed [31:0] h_prev,
	input  logic [5:0]         channel,
	input  logic [3:0]         state_idx,
	input  logic               first_step,
	input  logic               last_step,
	input  logic               q_full,
	output logic               q_push,
	output item_t              q_item
);

	// stall while the queue has no room
	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	// classify the beat
	always_comb begin
		q_item.step_size  = step_size;
		q_item.x_in       = x_in;
		q_item.grad_out   = grad_out;
		q_item.a_coef     = a_coef;
		q_item.b_in       = b_in;
		q_item.c_in       = c_in;
		q_item.h_cur      = h_cur;
		q_item.h_prev     = h_prev;
		q_item.channel    = channel;
		q_item.state_idx  = state_idx;
		q_item.first_step = first_step;
		q_item.last_step  = last_step;
		q_item.out_range  = (32'(channel) >= 32'(CHANNELS)) ||
			(32'(state_idx) >= 32'(STATE_SIZE));
		q_item.row_end    = (32'(state_idx) == 32'(STATE_SIZE - 1));
	end

endmodule

>>> rtl/ssb_queue.sv
// Two-entry queue between front and back.
// Depends on ssb_pkg for the item type.
module ssb_queue import ssb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	output logic  valid,
	input  logic  pop,
	output item_t dout
);

	item_t      mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = mem_q[rd_q];

	// store pushed beats
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/ssb_back.sv
// Back end: sequencer around one shared multiplier, adjoint and dA stores, running sums.
// Depends on ssb_pkg.
module ssb_back import ssb_pkg::*; #(
	parameter int CHANNELS   = 64,
	parameter int STATE_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] grad_c,
	output logic signed [31:0] grad_b,
	output logic signed [31:0] grad_x,
	output logic signed [31:0] grad_step,
	output logic               row_done,
	output logic signed [31:0] grad_a,
	output logic               grad_a_valid
);

	localparam int DEPTH = CHANNELS * STATE_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [4:0] ST_IDLE = 5'd0,  ST_RD  = 5'd1,  ST_Z   = 5'd2,  ST_AH  = 5'd3;
	localparam logic [4:0] ST_QE   = 5'd4,  ST_RM  = 5'd5,  ST_DT  = 5'd6,  ST_T1  = 5'd7;
	localparam logic [4:0] ST_T2   = 5'd8,  ST_T3  = 5'd9,  ST_EX  = 5'd10, ST_M1  = 5'd11;
	localparam logic [4:0] ST_M2   = 5'd12, ST_M3  = 5'd13, ST_M4  = 5'd14, ST_M5  = 5'd15;
	localparam logic [4:0] ST_M6   = 5'd16, ST_M7  = 5'd17, ST_M8  = 5'd18, ST_M9  = 5'd19;
	localparam logic [4:0] ST_M10  = 5'd20, ST_M11 = 5'd21, ST_WB  = 5'd22;

	logic [4:0]         state_q;
	logic               clr_busy_q;
	logic [AW-1:0]      clr_cnt_q;
	item_t              it_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] adj_mem [DEPTH];
	logic signed [31:0] acc_mem [DEPTH];
	logic signed [31:0] adj_rd_q, acc_rd_q, adj_q, acc_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [31:0] qp;
	logic signed [31:0] z_q, ah_q, ahdt_q, ex_q, acc_new_q, dx_q, t_q, dd_q;
	logic signed [31:0] gc_q, gb_q, adjn_q, gx_sum_q, gs_sum_q, gx_new, gs_new;
	logic signed [32:0] zb;
	logic [21:0]        zoff, r0;
	logic [5:0]         qest_q;
	logic [15:0]        r_q, p_c;
	logic [16:0]        term_q;
	logic [18:0]        e_q;
	logic [2:0]         i_q;
	logic signed [6:0]  k_c;
	logic [33:0]        sh_c;
	logic signed [31:0] ex_c;
	logic               load, wr_en;
	logic [AW-1:0]      rd_idx, wr_idx;
	logic signed [31:0] adj_wd, acc_wd;
	logic               res_valid_q;

	assign qp    = qsat(prod_q);
	assign q_pop = (state_q == ST_IDLE) && q_valid && !clr_busy_q;
	assign load  = (state_q == ST_WB) && (!res_valid_q || !res_stall);
	assign rd_idx = AW'(32'(q_item.channel) * 32'(STATE_SIZE) + 32'(q_item.state_idx));
	assign zb    = {z_q[31], z_q} + 33'(Z_BIAS);
	assign zoff  = zb[21:0];
	assign r0    = zoff - prod_q[21:0];
	assign p_c   = prod_q[31:16];
	assign k_c   = 7'($signed({1'b0, qest_q})) - 7'(K_OFFSET);
	assign gx_new = it_q.state_idx == 4'd0 ? dx_q : qadd(gx_sum_q, dx_q);
	assign gs_new = it_q.state_idx == 4'd0 ? dd_q : qadd(gs_sum_q, dd_q);

	// finish the exponential: scale the series by 2^k, saturating or flushing out of range
	always_comb begin
		sh_c = 34'(e_q) << k_c[3:0];
		if (z_q >= 32'(Z_HI)) begin
			ex_c = Q_MAX;
		end else if (z_q < 32'(Z_LO)) begin
			ex_c = 32'sd0;
		end else if (!k_c[6]) begin
			ex_c = (sh_c > 34'h7fffffff) ? Q_MAX : sh_c[31:0];
		end else begin
			ex_c = 32'(e_q >> 5'(-k_c));
		end
	end

	// pick multiplier operands for the current step
	always_comb begin
		ma = 33'sd0;
		mb = 33'sd0;
		case (state_q)
			ST_RD:  begin ma = {it_q.step_size[31], it_q.step_size};
				mb = {it_q.a_coef[31], it_q.a_coef}; end
			ST_Z:   begin ma = {it_q.grad_out[31], it_q.grad_out};
				mb = {it_q.c_in[31], it_q.c_in}; end
			ST_AH:  begin ma = {11'd0, zoff}; mb = 33'(RECIP_LN2); end
			ST_QE:  begin ma = {27'd0, prod_q[35:30]}; mb = 33'(LN2_Q16); end
			ST_RM:  begin ma = {ah_q[31], ah_q}; mb = {it_q.step_size[31], it_q.step_size}; end
			ST_T1:  begin ma = {16'd0, term_q}; mb = {17'd0, r_q}; end
			ST_T2:  begin ma = {17'd0, p_c}; mb = recip(i_q); end
			ST_M1:  begin ma = {ahdt_q[31], ahdt_q}; mb = {ex_q[31], ex_q}; end
			ST_M2:  begin ma = {qp[31], qp}; mb = {it_q.h_prev[31], it_q.h_prev}; end
			ST_M3:  begin ma = {ahdt_q[31], ahdt_q}; mb = {it_q.b_in[31], it_q.b_in}; end
			ST_M4:  begin ma = {it_q.a_coef[31], it_q.a_coef}; mb = {ex_q[31], ex_q}; end
			ST_M5:  begin ma = {qp[31], qp}; mb = {it_q.h_prev[31], it_q.h_prev}; end
			ST_M6:  begin ma = {it_q.b_in[31], it_q.b_in}; mb = {it_q.x_in[31], it_q.x_in}; end
			ST_M7:  begin ma = {ah_q[31], ah_q}; mb = 33'(qadd(t_q, qp)); end
			ST_M8:  begin ma = {it_q.grad_out[31], it_q.grad_out};
				mb = {it_q.h_cur[31], it_q.h_cur}; end
			ST_M9:  begin ma = {ahdt_q[31], ahdt_q}; mb = {it_q.x_in[31], it_q.x_in}; end
			ST_M10: begin ma = {ah_q[31], ah_q}; mb = {ex_q[31], ex_q}; end
			default: begin ma = 33'sd0; mb = 33'sd0; end
		endcase
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// datapath registers for each step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (q_pop) begin it_q <= q_item; idx_q <= rd_idx; end
			ST_RD:  begin
				adj_q <= it_q.first_step ? 32'sd0 : adj_rd_q;
				acc_q <= it_q.first_step ? 32'sd0 : acc_rd_q;
			end
			ST_Z:   z_q <= qp;
			ST_AH:  ah_q <= qadd(adj_q, qp);
			ST_QE:  qest_q <= prod_q[35:30];
			ST_RM:  begin
				if (r0 >= 22'(LN2_Q16)) begin
					r_q    <= 16'(r0 - 22'(LN2_Q16));
					qest_q <= qest_q + 6'd1;
				end else begin
					r_q <= r0[15:0];
				end
				term_q <= 17'h10000;
				e_q    <= 19'h10000;
				i_q    <= 3'd1;
			end
			ST_DT:  ahdt_q <= qp;
			ST_T2:  if (i_q == 3'd1) begin
				term_q <= {1'b0, p_c};
				e_q    <= e_q + 19'(p_c);
				i_q    <= 3'd2;
			end
			ST_T3:  begin
				term_q <= {1'b0, prod_q[47:32]};
				e_q    <= e_q + 19'(prod_q[47:32]);
				i_q    <= i_q + 3'd1;
			end
			ST_EX:  ex_q <= ex_c;
			ST_M3:  acc_new_q <= qadd(acc_q, qp);
			ST_M4:  dx_q <= qp;
			ST_M6:  t_q <= qp;
			ST_M8:  dd_q <= qp;
			ST_M9:  gc_q <= qp;
			ST_M10: gb_q <= qp;
			ST_M11: adjn_q <= qp;
			default: ;
		endcase
	end

	// step the sequencer and the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (q_pop) state_q <= q_item.out_range ? ST_WB : ST_RD;
				ST_T2:   state_q <= (i_q == 3'd1) ? ST_T1 : ST_T3;
				ST_T3:   state_q <= (i_q == 3'd6) ? ST_EX : ST_T1;
				ST_WB:   if (load) state_q <= ST_IDLE;
				default: state_q <= state_q + 5'd1;
			endcase
		end
	end

	// adjoint and dA stores: clear after reset, read on pop, write back on load
	assign wr_en  = clr_busy_q || (load && !it_q.out_range);
	assign wr_idx = clr_busy_q ? clr_cnt_q : idx_q;
	assign adj_wd = clr_busy_q ? 32'sd0 : adjn_q;
	assign acc_wd = clr_busy_q ? 32'sd0 : acc_new_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			adj_rd_q <= adj_mem[rd_idx];
			acc_rd_q <= acc_mem[rd_idx];
		end
		if (wr_en) begin
			adj_mem[wr_idx] <= adj_wd;
			acc_mem[wr_idx] <= acc_wd;
		end
	end

	// running channel sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_sum_q <= 32'sd0;
			gs_sum_q <= 32'sd0;
		end else if (load && !it_q.out_range) begin
			gx_sum_q <= gx_new;
			gs_sum_q <= gs_new;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (it_q.out_range) begin
				grad_c       <= 32'sd0;
				grad_b       <= 32'sd0;
				grad_x       <= 32'sd0;
				grad_step    <= 32'sd0;
				row_done     <= 1'b0;
				grad_a       <= 32'sd0;
				grad_a_valid <= 1'b0;
			end else begin
				grad_c       <= gc_q;
				grad_b       <= gb_q;
				grad_x       <= it_q.row_end ? gx_new : 32'sd0;
				grad_step    <= it_q.row_end ? gs_new : 32'sd0;
				row_done     <= it_q.row_end;
				grad_a       <= it_q.last_step ? acc_new_q : 32'sd0;
				grad_a_valid <= it_q.last_step;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

>>> rtl/selective_scan_backward.sv
// Reverse-time selective scan gradient, Q16.16 with saturation.
// One item in flight in the back end, which steps each item through the shared multiplier
// sequence (six-term exponential series plus the chain of dependent products in the M states)
// before it takes the next item from the queue.
// Reset: asynchronous, active low; afterwards a clearing pass over the CHANNELS*STATE_SIZE
// entries zeroes the adjoint and dA stores, while input beats queue but none is processed.
module selective_scan_backward import ssb_pkg::*; #(
	parameter int CHANNELS   = 64,
	parameter int STATE_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] step_size,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] grad_out,
	input  logic signed [31:0] a_coef,
	input  logic signed [31:0] b_in,
	input  logic signed [31:0] c_in,
	input  logic signed [31:0] h_cur,
	input  logic signed [31:0] h_prev,
	input  logic [5:0]         channel,
	input  logic [3:0]         state_idx,
	input  logic               first_step,
	input  logic               last_step,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] grad_c,
	output logic signed [31:0] grad_b,
	output logic signed [31:0] grad_x,
	output logic signed [31:0] grad_step,
	output logic               row_done,
	output logic signed [31:0] grad_a,
	output logic               grad_a_valid
);

	logic  q_push, q_full, q_valid, q_pop;
	item_t q_in, q_out;

	ssb_front #(.CHANNELS(CHANNELS), .STATE_SIZE(STATE_SIZE)) u_front (
		.item_valid, .item_stall, .step_size, .x_in, .grad_out, .a_coef, .b_in, .c_in,
		.h_cur, .h_prev, .channel, .state_idx, .first_step, .last_step,
		.q_full, .q_push, .q_item(q_in)
	);

	ssb_queue u_queue (
		.clk, .arst_n, .push(q_push), .din(q_in), .full(q_full),
		.valid(q_valid), .pop(q_pop), .dout(q_out)
	);

	ssb_back #(.CHANNELS(CHANNELS), .STATE_SIZE(STATE_SIZE)) u_back (
		.clk, .arst_n, .q_valid, .q_item(q_out), .q_pop,
		.res_valid, .res_stall, .grad_c, .grad_b, .grad_x, .grad_step,
		.row_done, .grad_a, .grad_a_valid
	);

endmodule

>>> rtl/ssb_checker.sv
// Port-level checks for the selective scan backward block, bound to the top level.
// Depends only on the top level's ports.
module ssb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input logic signed [31:0] grad_c,
	input logic signed [31:0] grad_x,
	input logic signed [31:0] grad_step,
	input logic               row_done,
	input logic signed [31:0] grad_a,
	input logic               grad_a_valid
);

	// a stalled result beat holds: valid stays and grad_c is stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(grad_c))
		else $error("stalled result changed");

	// channel sums show only on a row end
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !row_done |-> grad_x == 32'sd0 && grad_step == 32'sd0)
		else $error("sums shown off a row end");

	// dA shows only when final
	a_da: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !grad_a_valid |-> grad_a == 32'sd0)
		else $error("dA shown before final step");

endmodule

bind selective_scan_backward ssb_checker u_ssb_checker (.*);
